[design/bdq_pkg.sv]
// Shared types and codes for the bounded deque with indexed read.
package bdq_pkg;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_REM_HEAD = 3'd2,
    REQ_REM_TAIL = 3'd3,
    REQ_RD_HEAD  = 3'd4,
    REQ_RD_TAIL  = 3'd5,
    REQ_RD_INDEX = 3'd6
  } bdq_req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } bdq_status_t;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [DATA_W-1:0]  element_value;
    logic [INDEX_W-1:0] index;
  } bdq_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } bdq_out_t;

  typedef struct packed {
    logic               rd;
    logic [COUNT_W-1:0] count;
    bdq_status_t        status;
  } bdq_meta_t;

endpackage

[design/bdq_mem.sv]
// Single-port element store with registered read data.
module bdq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/bdq_ctrl.sv]
// Head pointer, element count, request decode and store address generation.
module bdq_ctrl #(
  parameter int CAPACITY = 256,
  parameter int ELEMENT_WIDTH = 32,
  parameter int PW = 8,
  parameter int CW = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  bdq_pkg::bdq_in_t         req,
  output logic                     mem_we,
  output logic                     mem_re,
  output logic [PW-1:0]            mem_addr,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata,
  output bdq_pkg::bdq_meta_t       meta
);
  import bdq_pkg::*;

  localparam int SW = CW + 1;
  localparam int XW = (SW > INDEX_W) ? SW : INDEX_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S     = SW'(CAPACITY);

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] pos, sum, wrap;
  logic [PW-1:0] slot, head_dec, head_inc;
  logic [SW-1:0] idx_ext, cnt_ext;
  logic [XW-1:0] idx_cmp, cnt_cmp;
  logic [DATA_W+ELEMENT_WIDTH-1:0] wext;
  logic [SW+COUNT_W-1:0] cext;
  logic [1:0] status;
  logic full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign idx_ext  = SW'(req.index);
  assign cnt_ext  = SW'(cnt_r);
  assign idx_cmp  = XW'(req.index);
  assign cnt_cmp  = XW'(cnt_r);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - PW'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + PW'(1);

  always_comb begin
    case (req.req_type)
      REQ_INS_TAIL: pos = cnt_ext;
      REQ_RD_TAIL:  pos = cnt_ext - SW'(1);
      REQ_RD_INDEX: pos = idx_ext;
      default:      pos = '0;
    endcase
  end

  assign sum  = SW'(head_r) + pos;
  assign wrap = (sum >= CAP_S) ? sum - CAP_S : sum;
  assign slot = wrap[PW-1:0];

  assign wext      = {{ELEMENT_WIDTH{1'b0}}, req.element_value};
  assign mem_wdata = wext[ELEMENT_WIDTH-1:0];

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = slot;
    status   = ST_OK;
    case (req.req_type)
      REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_we  = acc;
          cnt_nxt = acc ? cnt_r + CW'(1) : cnt_r;
          if (req.req_type == REQ_INS_HEAD) begin
            mem_addr = head_dec;
            head_nxt = acc ? head_dec : head_r;
          end
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cnt_nxt = acc ? cnt_r - CW'(1) : cnt_r;
          if (req.req_type == REQ_REM_HEAD && acc) begin
            head_nxt = head_inc;
          end
        end
      end
      REQ_RD_HEAD, REQ_RD_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          mem_re = acc;
        end
      end
      REQ_RD_INDEX: begin
        if (idx_cmp >= cnt_cmp) begin
          status = ST_BADIDX;
        end else begin
          mem_re = acc;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign cext        = {{COUNT_W{1'b0}}, SW'(cnt_nxt)};
  assign meta.rd     = mem_re;
  assign meta.count  = cext[COUNT_W-1:0];
  assign meta.status = bdq_status_t'(status);

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("element count above capacity");
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && meta.status != ST_OK |=> $stable(cnt_r) && $stable(head_r))
    else $error("refused request changed state");
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store written and read by one request");
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(cnt_r) && $stable(head_r))
    else $error("state moved without a request");
`endif

endmodule

[design/bounded_deque_with_indexed_read.sv]
// Bounded deque with indexed read: top level with store, control and output stage.
//
// Requests enter on in_valid/in_stall/in_data; results leave on
// out_valid/out_stall/out_data, exactly one result per request, in order.
// A request is taken at a rising edge with in_valid high and in_stall low.
// Pointer and count update at that edge and the store is written or read
// through its single port there; the read word and the status sit in a
// holding stage after that edge and move to the output register at the
// first later edge at which out_stall does not hold it. Throughput is one
// request per cycle while out_stall lets results drain, set by the one store access each
// request makes; a write is visible to the very next request's read.
// While out_stall holds a full output register, the holding stage keeps
// the next result and in_stall rises once both are occupied; nothing is
// dropped. Reset (rst_n low at a clock edge) empties the deque, clears
// head pointer and count and discards results in flight. Store contents
// are not cleared: only slots holding elements are ever read.
// Status codes: ok, full (insert refused), empty (remove or end read
// refused), bad index; refused requests change nothing and read zero.
module bounded_deque_with_indexed_read #(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdq_pkg::bdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bdq_pkg::bdq_out_t out_data
);
  import bdq_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                     in_acc, s1_adv;
  logic                     mem_we, mem_re;
  logic [PW-1:0]            mem_addr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;
  bdq_meta_t                meta, s1_meta_r;
  logic                     s1_v_r, s1_v_nxt, out_v_r, out_v_nxt;
  bdq_out_t                 out_r, s1_res;
  logic [DATA_W+ELEMENT_WIDTH-1:0] rext;

  bdq_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .PW            (PW),
    .CW            (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .req       (in_data),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta      (meta)
  );

  bdq_mem #(
    .DEPTH (CAPACITY),
    .AW    (PW),
    .DW    (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign s1_adv   = !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign rext             = {{DATA_W{1'b0}}, mem_rdata};
  assign s1_res.read_data = s1_meta_r.rd ? rext[DATA_W-1:0] : '0;
  assign s1_res.count     = s1_meta_r.count;
  assign s1_res.status    = s1_meta_r.status;

  assign s1_v_nxt  = in_acc || (s1_v_r && !s1_adv);
  assign out_v_nxt = s1_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_meta_r <= meta;
    end
    if (s1_adv && s1_v_r) begin
      out_r <= s1_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && out_stall |-> in_stall)
    else $error("request taken with both result stages full");
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_meta_r))
    else $error("held result lost");
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status != ST_OK |-> out_r.read_data == '0)
    else $error("refused request returned data");
`endif

endmodule

[sim/tb_top.sv]
// Testbench for bounded_deque_with_indexed_read: random and directed requests checked in order.
`timescale 1ns / 1ps

module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH = 256;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_PCT = 23;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  class deque_scoreboard;
    logic [DATA_W-1:0] slots [DEPTH];
    int unsigned head;
    int unsigned held;
    bdq_out_t due_results [$];
    int errors;

    function new();
      head = 0;
      held = 0;
      errors = 0;
    endfunction

    function void note_request(bdq_in_t req);
      bdq_out_t r;
      r.read_data = '0;
      r.status = ST_OK;
      case (req.req_type)
        REQ_INS_HEAD, REQ_INS_TAIL: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else if (req.req_type == REQ_INS_HEAD) begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = req.element_value;
            held++;
          end else begin
            slots[(head + held) % DEPTH] = req.element_value;
            held++;
          end
        end
        REQ_REM_HEAD, REQ_REM_TAIL: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (req.req_type == REQ_REM_HEAD) head = (head + 1) % DEPTH;
            held--;
          end
        end
        REQ_RD_HEAD, REQ_RD_TAIL: begin
          if (held == 0) r.status = ST_EMPTY;
          else if (req.req_type == REQ_RD_HEAD) r.read_data = slots[head];
          else r.read_data = slots[(head + held - 1) % DEPTH];
        end
        REQ_RD_INDEX: begin
          if (req.index >= held) r.status = ST_BADIDX;
          else r.read_data = slots[(head + req.index) % DEPTH];
        end
        default: begin
        end
      endcase
      r.count = held[COUNT_W-1:0];
      due_results.push_back(r);
    endfunction

    function void check_result(bdq_out_t got);
      bdq_out_t want;
      if (due_results.size() == 0) begin
        $error("result with no request pending: %h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bdq_in_t in_data;
  logic out_valid;
  logic out_stall;
  bdq_out_t out_data;

  deque_scoreboard sb;
  int sent = 0;
  int idle_cycles = 0;

  bounded_deque_with_indexed_read uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !(sent >= 1000 && sent < 1250)
                 && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("bounded_deque_with_indexed_read regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bdq_in_t make_req(logic [2:0] kind, logic [DATA_W-1:0] value,
                                       logic [INDEX_W-1:0] idx);
    bdq_in_t r;
    r.req_type = kind;
    r.element_value = value;
    r.index = idx;
    return r;
  endfunction

  function automatic bdq_in_t random_request(int unsigned held, bit filling);
    int roll;
    logic [2:0] kind;
    logic [INDEX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    if (roll >= 97) kind = REQ_UNUSED;
    else if (roll >= 70) begin
      case ($urandom_range(0, 3))
        0: kind = REQ_RD_HEAD;
        1: kind = REQ_RD_TAIL;
        default: kind = REQ_RD_INDEX;
      endcase
    end else if ((filling && roll < 65) || (!filling && roll < 5))
      kind = $urandom_range(0, 1) ? REQ_INS_HEAD : REQ_INS_TAIL;
    else
      kind = $urandom_range(0, 1) ? REQ_REM_HEAD : REQ_REM_TAIL;
    if (held == 0 || $urandom_range(0, 4) == 0) idx = INDEX_W'($urandom_range(0, 255));
    else idx = INDEX_W'($urandom_range(0, held - 1));
    return make_req(kind, $urandom(), idx);
  endfunction

  task automatic send_request(input bdq_in_t req);
    while (!(sent >= 700 && sent < 900) && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    sent++;
  endtask

  initial begin
    bit filling;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(make_req(REQ_RD_HEAD, 32'h0, 8'd0));
    send_request(make_req(REQ_RD_TAIL, 32'h0, 8'd0));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd0));
    send_request(make_req(REQ_REM_HEAD, 32'hFFFF_FFFF, 8'd255));
    send_request(make_req(REQ_REM_TAIL, 32'h0, 8'd0));
    send_request(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 8'd255));
    send_request(make_req(REQ_INS_HEAD, 32'h0000_0000, 8'd0));
    send_request(make_req(REQ_INS_TAIL, 32'hFFFF_FFFF, 8'd255));
    send_request(make_req(REQ_INS_HEAD, 32'hA5A5_5A5A, 8'd128));
    send_request(make_req(REQ_RD_HEAD, 32'h0, 8'd0));
    send_request(make_req(REQ_RD_TAIL, 32'h0, 8'd0));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd0));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd1));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd2));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd3));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd255));
    send_request(make_req(REQ_REM_HEAD, 32'h0, 8'd0));
    send_request(make_req(REQ_REM_TAIL, 32'h0, 8'd0));
    send_request(make_req(REQ_RD_INDEX, 32'h0, 8'd0));
    send_request(make_req(REQ_UNUSED, 32'h1234_5678, 8'd0));
    send_request(make_req(REQ_REM_HEAD, 32'h0, 8'd0));
    send_request(make_req(REQ_REM_TAIL, 32'h0, 8'd0));

    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (sb.held == DEPTH && $urandom_range(0, 15) == 0) filling = 1'b0;
      else if (sb.held == 0 && $urandom_range(0, 15) == 0) filling = 1'b1;
      send_request(random_request(sb.held, filling));
    end
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("bounded_deque_with_indexed_read regression: pass");
    end else begin
      $display("bounded_deque_with_indexed_read regression: fail");
    end
    $finish;
  end

endmodule
